/* rtl/core/hrc_pkg.sv */
// ----------------------------------------------------------------------------
// hrc_pkg: shared constants for hyperbolic radius compression
// Field widths, pipeline depths and configuration register indexes.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int RadiusW  = 24;
  localparam int DiffW    = RadiusW + 1;
  localparam int GainW    = 24;
  localparam int OffsetW  = 32;
  localparam int SoftW    = 48;
  localparam int SumW     = 50;
  localparam int RootW    = 25;
  localparam int ProdW    = GainW + DiffW;
  localparam int FracGain = 16;
  localparam int QuotW    = FracGain + 1;
  localparam int NumerW   = RadiusW + FracGain + 1;
  localparam int SqrtSteps = RootW;
  localparam int DivSteps  = QuotW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic signed [GainW-1:0] GainReset = GainW'(65536);
  localparam logic [RadiusW-1:0] CompMax = {RadiusW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER = 3'd0,
    CFG_GAIN   = 3'd1,
    CFG_OFFSET = 3'd2,
    CFG_SOFT   = 3'd3
  } cfg_idx_t;

endpackage

/* rtl/core/hyperbolic_radius_compression_top.sv */
// ----------------------------------------------------------------------------
// hyperbolic_radius_compression_top
// Computes the compressed radius and the slope of the compression curve.
// ----------------------------------------------------------------------------
// The block takes one radius per clock while the output is not stalled and
// returns one result word per radius, in order. The depth is set by the square
// root, which resolves one result bit per stage over 25 stages, and by the slope
// divider, which resolves one quotient bit per stage over 17 stages. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so a stall at the output holds every word in place. Configuration
// registers are read live and must only be written while no word is in flight.
module hyperbolic_radius_compression_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hrc_pkg::RadiusW-1:0]     radius,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hrc_pkg::RadiusW-1:0]     compressed_radius,
  output logic signed [hrc_pkg::GainW-1:0] slope,
  output logic                            zero_root,
  input  logic                            cfg_we,
  input  logic [hrc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [hrc_pkg::CfgDataW-1:0]    cfg_data
);
  import hrc_pkg::*;

  logic [RadiusW-1:0]       center_radius;
  logic signed [GainW-1:0]  slope_gain;
  logic signed [OffsetW-1:0] offset_term;
  logic [SoftW-1:0]         softness_square;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_radius   <= '0;
      slope_gain      <= GainReset;
      offset_term     <= '0;
      softness_square <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER: center_radius   <= cfg_data[RadiusW-1:0];
        CFG_GAIN:   slope_gain      <= cfg_data[GainW-1:0];
        CFG_OFFSET: offset_term     <= cfg_data[OffsetW-1:0];
        CFG_SOFT:   softness_square <= cfg_data[SoftW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage A: signed offset from the knee and its magnitude.
  logic                     a_v, a_neg;
  logic [RadiusW-1:0]       a_ad;
  logic signed [DiffW-1:0]  a_d;
  logic signed [DiffW-1:0]  d_in;
  assign d_in = $signed({1'b0, radius}) - $signed({1'b0, center_radius});

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_valid;
    if (en) begin
      a_d   <= d_in;
      a_neg <= d_in[DiffW-1];
      a_ad  <= d_in[DiffW-1] ? RadiusW'(-d_in) : RadiusW'(d_in);
    end
  end

  // Stage B: square and gain product.
  logic                     b_v, b_neg;
  logic [RadiusW-1:0]       b_ad;
  logic [2*RadiusW-1:0]     b_sq;
  logic signed [ProdW-1:0]  b_gp;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
    if (en) begin
      b_neg <= a_neg;
      b_ad  <= a_ad;
      b_sq  <= a_ad * a_ad;
      b_gp  <= ProdW'(slope_gain) * ProdW'(a_d);
    end
  end

  // Stage C: radicand.
  logic                     c_v, c_neg;
  logic [RadiusW-1:0]       c_ad;
  logic [SumW-1:0]          c_sum;
  logic signed [ProdW-1:0]  c_gp;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
    if (en) begin
      c_neg <= b_neg;
      c_ad  <= b_ad;
      c_sum <= SumW'(b_sq) + SumW'(softness_square);
      c_gp  <= b_gp;
    end
  end

  // Square root, one result bit per stage.
  logic                    s_v   [SqrtSteps+1];
  logic                    s_neg [SqrtSteps+1];
  logic [RadiusW-1:0]      s_ad  [SqrtSteps+1];
  logic [SumW-1:0]         s_rem [SqrtSteps+1];
  logic [SumW-1:0]         s_res [SqrtSteps+1];
  logic signed [ProdW-1:0] s_gp  [SqrtSteps+1];

  assign s_v[0]   = c_v;
  assign s_neg[0] = c_neg;
  assign s_ad[0]  = c_ad;
  assign s_rem[0] = c_sum;
  assign s_res[0] = '0;
  assign s_gp[0]  = c_gp;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SumW-1:0] Bit = SumW'(1) << (2 * (SqrtSteps - 1 - k));
    logic [SumW-1:0] trial;
    logic            take;
    assign trial = s_res[k] + Bit;
    assign take  = s_rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) s_v[k+1] <= 1'b0;
      else if (en) s_v[k+1] <= s_v[k];
      if (en) begin
        s_neg[k+1] <= s_neg[k];
        s_ad[k+1]  <= s_ad[k];
        s_gp[k+1]  <= s_gp[k];
        s_rem[k+1] <= take ? s_rem[k] - trial : s_rem[k];
        s_res[k+1] <= take ? (s_res[k] >> 1) + Bit : s_res[k] >> 1;
      end
    end
  end

  // Ratio |d| * 2^16 / root, one quotient bit per stage.
  logic                    q_v    [DivSteps+1];
  logic                    q_neg  [DivSteps+1];
  logic [RootW-1:0]        q_root [DivSteps+1];
  logic [NumerW-1:0]       q_rem  [DivSteps+1];
  logic [QuotW-1:0]        q_quo  [DivSteps+1];
  logic signed [ProdW-1:0] q_gp   [DivSteps+1];

  assign q_v[0]    = s_v[SqrtSteps];
  assign q_neg[0]  = s_neg[SqrtSteps];
  assign q_root[0] = s_res[SqrtSteps][RootW-1:0];
  assign q_rem[0]  = {1'b0, s_ad[SqrtSteps], {FracGain{1'b0}}};
  assign q_quo[0]  = '0;
  assign q_gp[0]   = s_gp[SqrtSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Sh = DivSteps - 1 - j;
    logic [NumerW+QuotW-1:0] dshift;
    logic                    take;
    assign dshift = (NumerW+QuotW)'(q_root[j]) << Sh;
    assign take   = (NumerW+QuotW)'(q_rem[j]) >= dshift;

    always_ff @(posedge clk) begin
      if (rst) q_v[j+1] <= 1'b0;
      else if (en) q_v[j+1] <= q_v[j];
      if (en) begin
        q_neg[j+1]  <= q_neg[j];
        q_root[j+1] <= q_root[j];
        q_gp[j+1]   <= q_gp[j];
        q_rem[j+1]  <= take ? q_rem[j] - NumerW'(dshift) : q_rem[j];
        q_quo[j+1]  <= q_quo[j] | (take ? QuotW'(1) << Sh : '0);
      end
    end
  end

  // Output stage: combine, clamp and saturate.
  logic [RootW-1:0]        f_root;
  logic signed [35:0]      comp_full;
  logic signed [GainW+2:0] ratio, slope_full;
  logic                    f_zero;

  always_comb begin
    f_root    = q_root[DivSteps];
    f_zero    = f_root == '0;
    comp_full = 36'(offset_term) + 36'(q_gp[DivSteps] >>> FracGain)
              - $signed(36'(f_root));
    ratio     = $signed((GainW+3)'(q_quo[DivSteps]));
    if (q_neg[DivSteps]) ratio = -ratio;
    slope_full = f_zero ? (GainW+3)'(slope_gain) : ratio + (GainW+3)'(slope_gain);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= q_v[DivSteps];
    if (en) begin
      zero_root <= f_zero;
      if (comp_full < 0) compressed_radius <= '0;
      else if (comp_full > $signed(36'(CompMax))) compressed_radius <= CompMax;
      else compressed_radius <= comp_full[RadiusW-1:0];
      if (slope_full > (GainW+3)'(8388607)) slope <= GainW'(8388607);
      else if (slope_full < -(GainW+3)'(8388608)) slope <= GainW'(-8388608);
      else slope <= slope_full[GainW-1:0];
    end
  end

endmodule

/* rtl/core/hrc_checker.sv */
// ----------------------------------------------------------------------------
// hrc_checker: port-level checks for hyperbolic_radius_compression_top
// Watches the handshakes on the top-level ports.
// ----------------------------------------------------------------------------
module hrc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [hrc_pkg::RadiusW-1:0]      compressed_radius,
  input logic signed [hrc_pkg::GainW-1:0] slope,
  input logic                             zero_root
);
  import hrc_pkg::*;

  // The pipeline only moves when the output word can leave.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output slot");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(compressed_radius)
      && $stable(slope) && $stable(zero_root))
    else $error("stalled output word changed");

endmodule

bind hyperbolic_radius_compression_top hrc_checker u_hrc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .compressed_radius(compressed_radius),
  .slope(slope), .zero_root(zero_root)
);
